// ----- hdl/cbez_pkg.sv -----
// Shared types and constants for the cubic Bezier evaluate/subdivide unit.
// Used by every module of the block; depends on nothing else.
package cbez_pkg;

    // Field widths
    localparam int COORD_BITS   = 16;
    localparam int T_FRAC_BITS  = 16;
    localparam int T_BITS       = T_FRAC_BITS + 1;
    localparam int CFG_IDX_BITS = 4;
    localparam int NUM_REGS     = 8;
    localparam int REG_SEL_BITS = $clog2(NUM_REGS);
    localparam int IDX_BITS     = 3;

    // Internal arithmetic runs modulo 2^64, split in halves for the multipliers
    localparam int ACC_BITS  = 64;
    localparam int HALF_BITS = ACC_BITS / 2;

    // Input queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Register indexes of the x coordinate of each control point (y follows)
    localparam logic [REG_SEL_BITS-1:0] REG_P0_X = REG_SEL_BITS'(0);
    localparam logic [REG_SEL_BITS-1:0] REG_P1_X = REG_SEL_BITS'(2);
    localparam logic [REG_SEL_BITS-1:0] REG_P2_X = REG_SEL_BITS'(4);
    localparam logic [REG_SEL_BITS-1:0] REG_P3_X = REG_SEL_BITS'(6);

    // Mode codes
    localparam logic MODE_EVAL  = 1'b0;
    localparam logic MODE_SPLIT = 1'b1;

    // t = 1.0 and the index of the final subdivision point
    localparam logic [T_BITS-1:0]   T_ONE    = {1'b1, {T_FRAC_BITS{1'b0}}};
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(7);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [ACC_BITS-1:0] t_acc;
    typedef logic [NUM_REGS-1:0][COORD_BITS-1:0] t_cfg_regs;

    typedef struct packed {
        logic [T_BITS-1:0] t_value;
        logic              mode;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic [IDX_BITS-1:0]          point_index;
        logic                         last_point;
    } t_out_item;

    // Classified job handed from front to back
    typedef struct packed {
        logic [T_BITS-1:0] t_sat;
        logic              split;
    } t_job;

endpackage

// ----- hdl/cbez_front.sv -----
// Front end: takes input beats, clamps t to 1.0 and classifies the mode.
// Depends on cbez_pkg; feeds cbez_queue.
module cbez_front (
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cbez_pkg::t_in_item i_in_data,
    output logic              o_push_valid,
    input  logic              i_push_ready,
    output cbez_pkg::t_job    o_push_data
);

    // Accept whenever the queue has room
    assign o_in_ready   = i_push_ready;
    assign o_push_valid = i_in_valid;

    // Clamp t above one, decode mode
    always_comb begin
        o_push_data.t_sat = (i_in_data.t_value > cbez_pkg::T_ONE) ? cbez_pkg::T_ONE
                                                                   : i_in_data.t_value;
        o_push_data.split = (i_in_data.mode == cbez_pkg::MODE_SPLIT);
    end

endmodule

// ----- hdl/cbez_queue.sv -----
// Short job queue that decouples the front end from the arithmetic back end.
// Depends on cbez_pkg.
module cbez_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  cbez_pkg::t_job i_push_data,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output cbez_pkg::t_job o_pop_data
);

    localparam int PTR_BITS = $clog2(cbez_pkg::QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(cbez_pkg::QUEUE_DEPTH + 1);

    cbez_pkg::t_job        r_mem [cbez_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   r_wr_ptr;
    logic [PTR_BITS-1:0]   r_rd_ptr;
    logic [CNT_BITS-1:0]   r_count;
    logic                  push;
    logic                  pop;

    assign o_push_ready = (r_count != CNT_BITS'(cbez_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_BITS'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_BITS'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_BITS'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_BITS'(1);
            end
        end
    end

endmodule

// ----- hdl/cbez_back.sv -----
// Back end: five-stage De Casteljau pipeline (x and y lanes), result
// sequencer and output register. Depends on cbez_pkg.
module cbez_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cbez_pkg::t_cfg_regs i_cfg,
    input  logic                i_job_valid,
    output logic                o_job_ready,
    input  cbez_pkg::t_job      i_job,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output cbez_pkg::t_out_item o_out_data
);

    localparam int LANES     = 2;
    localparam int STAGES    = 5;
    localparam int F         = cbez_pkg::T_FRAC_BITS;
    localparam int CB        = cbez_pkg::COORD_BITS;
    localparam int HB        = cbez_pkg::HALF_BITS;
    localparam int AB        = cbez_pkg::ACC_BITS;
    localparam int TB        = cbez_pkg::T_BITS;
    localparam int PRD_BITS  = CB + TB + 2;
    localparam int IB        = cbez_pkg::IDX_BITS;

    // Sign extension of a coordinate into the accumulator width
    function automatic cbez_pkg::t_acc f_sext(input logic [CB-1:0] c);
        return {{(AB-CB){c[CB-1]}}, c};
    endfunction

    // First lerp level: (pa << F) + (pb - pa) * t
    function automatic cbez_pkg::t_acc f_lerp1(input logic [CB-1:0] pa,
                                               input logic [CB-1:0] pb,
                                               input logic [TB-1:0] t);
        logic signed [CB:0]       d;
        logic signed [PRD_BITS-1:0] p;
        d = {pb[CB-1], pb} - {pa[CB-1], pa};
        p = PRD_BITS'(d) * PRD_BITS'($signed({1'b0, t}));
        return (f_sext(pa) << F) + {{(AB-PRD_BITS){p[PRD_BITS-1]}}, p};
    endfunction

    // Low half of e * t, mod 2^64
    function automatic cbez_pkg::t_acc f_mul_lo(input cbez_pkg::t_acc e,
                                                input logic [TB-1:0] t);
        cbez_pkg::t_acc lo;
        lo = cbez_pkg::t_acc'(e[HB-1:0]) * cbez_pkg::t_acc'(t);
        return lo;
    endfunction

    // High half of e * t, only its bits below 2^32 matter
    function automatic logic [HB-1:0] f_mul_hi(input cbez_pkg::t_acc e,
                                               input logic [TB-1:0] t);
        logic [HB-1:0] hi;
        hi = e[AB-1:HB] * HB'(t);
        return hi;
    endfunction

    // Recombine: (base << F) + lo + (hi << 32)
    function automatic cbez_pkg::t_acc f_sum(input cbez_pkg::t_acc base,
                                             input cbez_pkg::t_acc lo,
                                             input logic [HB-1:0] hi);
        return (base << F) + lo + {hi, {HB{1'b0}}};
    endfunction

    // Round to nearest (half toward plus infinity) and drop k fraction bits
    function automatic cbez_pkg::t_coord f_round(input cbez_pkg::t_acc v, input int k);
        cbez_pkg::t_acc w;
        cbez_pkg::t_acc sh;
        w = v;
        if (k < AB) begin
            w  = v + (cbez_pkg::t_acc'(1) << (k - 1));
            sh = cbez_pkg::t_acc'($signed(w) >>> k);
        end else if (k == AB) begin
            w  = v + (cbez_pkg::t_acc'(1) << (k - 1));
            sh = {AB{w[AB-1]}};
        end else begin
            sh = {AB{v[AB-1]}};
        end
        return sh[CB-1:0];
    endfunction

    // Pipeline control
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] r_split;
    logic [TB-1:0]     r_s1_t;
    logic [TB-1:0]     r_s2_t;
    logic [TB-1:0]     r_s3_t;

    // Stage 1: first-level points a1..a3
    cbez_pkg::t_acc r_s1_a [LANES][3];
    cbez_pkg::t_acc n_s1_a [LANES][3];
    // Stage 2: a carried, partial products of the second level
    cbez_pkg::t_acc r_s2_a  [LANES][3];
    cbez_pkg::t_acc r_s2_lo [LANES][2];
    logic [HB-1:0]  r_s2_hi [LANES][2];
    cbez_pkg::t_acc n_s2_lo [LANES][2];
    logic [HB-1:0]  n_s2_hi [LANES][2];
    // Stage 3: second-level points b1, b2
    cbez_pkg::t_acc r_s3_a1 [LANES];
    cbez_pkg::t_acc r_s3_a3 [LANES];
    cbez_pkg::t_acc r_s3_b  [LANES][2];
    cbez_pkg::t_acc n_s3_b  [LANES][2];
    // Stage 4: partial products of the third level
    cbez_pkg::t_acc r_s4_a1 [LANES];
    cbez_pkg::t_acc r_s4_a3 [LANES];
    cbez_pkg::t_acc r_s4_b  [LANES][2];
    cbez_pkg::t_acc r_s4_lo [LANES];
    logic [HB-1:0]  r_s4_hi [LANES];
    cbez_pkg::t_acc n_s4_lo [LANES];
    logic [HB-1:0]  n_s4_hi [LANES];
    // Stage 5: split point c
    cbez_pkg::t_acc r_s5_a1 [LANES];
    cbez_pkg::t_acc r_s5_a3 [LANES];
    cbez_pkg::t_acc r_s5_b  [LANES][2];
    cbez_pkg::t_acc r_s5_c  [LANES];
    cbez_pkg::t_acc n_s5_c  [LANES];

    // Sequencer: rounded points p21, p31, p4, p32, p23 per lane
    localparam int SL_P21 = 0;
    localparam int SL_P31 = 1;
    localparam int SL_P4  = 2;
    localparam int SL_P32 = 3;
    localparam int SL_P23 = 4;
    cbez_pkg::t_coord    r_pt [LANES][5];
    cbez_pkg::t_coord    n_pt [LANES][5];
    logic                r_seq_vld;
    logic                r_seq_split;
    logic [IB-1:0]       r_seq_idx;
    logic                r_out_vld;
    cbez_pkg::t_out_item r_out;
    cbez_pkg::t_coord    sel [LANES];

    logic en;
    logic load;
    logic emit;
    logic seq_last;
    logic seq_done;
    logic out_free;

    // Handshake between pipeline, sequencer and output register
    assign out_free    = !r_out_vld || i_out_ready;
    assign emit        = r_seq_vld && out_free;
    assign seq_last    = !r_seq_split || (r_seq_idx == cbez_pkg::LAST_IDX);
    assign seq_done    = emit && seq_last;
    assign load        = r_vld[STAGES-1] && (!r_seq_vld || seq_done);
    assign en          = !r_vld[STAGES-1] || load;
    assign o_job_ready = en;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Datapath arithmetic per lane
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_s1_a[l][0] = f_lerp1(i_cfg[cbez_pkg::REG_P0_X + l],
                                   i_cfg[cbez_pkg::REG_P1_X + l], i_job.t_sat);
            n_s1_a[l][1] = f_lerp1(i_cfg[cbez_pkg::REG_P1_X + l],
                                   i_cfg[cbez_pkg::REG_P2_X + l], i_job.t_sat);
            n_s1_a[l][2] = f_lerp1(i_cfg[cbez_pkg::REG_P2_X + l],
                                   i_cfg[cbez_pkg::REG_P3_X + l], i_job.t_sat);
            for (int j = 0; j < 2; j++) begin
                n_s2_lo[l][j] = f_mul_lo(r_s1_a[l][j+1] - r_s1_a[l][j], r_s1_t);
                n_s2_hi[l][j] = f_mul_hi(r_s1_a[l][j+1] - r_s1_a[l][j], r_s1_t);
                n_s3_b[l][j]  = f_sum(r_s2_a[l][j], r_s2_lo[l][j], r_s2_hi[l][j]);
            end
            n_s4_lo[l] = f_mul_lo(r_s3_b[l][1] - r_s3_b[l][0], r_s3_t);
            n_s4_hi[l] = f_mul_hi(r_s3_b[l][1] - r_s3_b[l][0], r_s3_t);
            n_s5_c[l]  = f_sum(r_s4_b[l][0], r_s4_lo[l], r_s4_hi[l]);
            n_pt[l][SL_P21] = f_round(r_s5_a1[l], F);
            n_pt[l][SL_P23] = f_round(r_s5_a3[l], F);
            n_pt[l][SL_P31] = f_round(r_s5_b[l][0], 2 * F);
            n_pt[l][SL_P32] = f_round(r_s5_b[l][1], 2 * F);
            n_pt[l][SL_P4]  = f_round(r_s5_c[l], 3 * F);
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_t <= i_job.t_sat;
            r_s2_t <= r_s1_t;
            r_s3_t <= r_s2_t;
            for (int l = 0; l < LANES; l++) begin
                for (int j = 0; j < 3; j++) begin
                    r_s1_a[l][j] <= n_s1_a[l][j];
                    r_s2_a[l][j] <= r_s1_a[l][j];
                end
                for (int j = 0; j < 2; j++) begin
                    r_s2_lo[l][j] <= n_s2_lo[l][j];
                    r_s2_hi[l][j] <= n_s2_hi[l][j];
                    r_s3_b[l][j]  <= n_s3_b[l][j];
                    r_s4_b[l][j]  <= r_s3_b[l][j];
                    r_s5_b[l][j]  <= r_s4_b[l][j];
                end
                r_s3_a1[l] <= r_s2_a[l][0];
                r_s3_a3[l] <= r_s2_a[l][2];
                r_s4_a1[l] <= r_s3_a1[l];
                r_s4_a3[l] <= r_s3_a3[l];
                r_s4_lo[l] <= n_s4_lo[l];
                r_s4_hi[l] <= n_s4_hi[l];
                r_s5_a1[l] <= r_s4_a1[l];
                r_s5_a3[l] <= r_s4_a3[l];
                r_s5_c[l]  <= n_s5_c[l];
            end
        end
    end

    // Pipeline valid and mode flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[STAGES-2:0], i_job_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_split <= {r_split[STAGES-2:0], i_job.split};
        end
    end

    // Select the point for the current run position
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            case (r_seq_idx)
                3'd0:    sel[l] = r_seq_split ? i_cfg[cbez_pkg::REG_P0_X + l]
                                              : r_pt[l][SL_P4];
                3'd1:    sel[l] = r_pt[l][SL_P21];
                3'd2:    sel[l] = r_pt[l][SL_P31];
                3'd5:    sel[l] = r_pt[l][SL_P32];
                3'd6:    sel[l] = r_pt[l][SL_P23];
                3'd7:    sel[l] = i_cfg[cbez_pkg::REG_P3_X + l];
                default: sel[l] = r_pt[l][SL_P4];
            endcase
        end
    end

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_vld <= 1'b0;
            r_seq_idx <= '0;
        end else if (load) begin
            r_seq_vld <= 1'b1;
            r_seq_idx <= '0;
        end else if (seq_done) begin
            r_seq_vld <= 1'b0;
        end else if (emit) begin
            r_seq_idx <= r_seq_idx + IB'(1);
        end
    end

    // Sequencer payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_seq_split <= r_split[STAGES-1];
            r_pt        <= n_pt;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.point_x     <= sel[0];
            r_out.point_y     <= sel[1];
            r_out.point_index <= r_seq_idx;
            r_out.last_point  <= seq_last;
        end
    end

endmodule

// ----- hdl/cubic_bezier_eval_subdivide_top.sv -----
// Top level of the cubic Bezier evaluate/subdivide unit: control point
// registers plus front end, job queue and arithmetic back end.
// Depends on cbez_pkg, cbez_front, cbez_queue and cbez_back.
//
// Usage:
//   Control points P0..P3 are written through the configuration channel,
//   index 0..7 = p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y; other
//   indexes are ignored. The channel is always ready. Write only while the
//   block is idle.
//   Each input beat carries t (Q1.16, values above 1.0 clamp to 1.0) and a
//   mode. Mode 0 yields one beat, the point on the curve at t. Mode 1 yields
//   eight beats: P0, p21, p31, p4, p4, p32, p23, P3, the last one flagged.
//   The first result beat for an input beat passes through the queue, the
//   five pipeline stages, the sequencer and the output register.
//   Throughput: one beat per cycle on the result channel while the receiver
//   is ready, so mode 0 items run at one per cycle and a mode 1 item takes
//   eight result beats; the single result port sets this figure. A two-entry
//   queue keeps input beats flowing while the back end is busy.
//   When the receiver stalls, the output register holds its beat, the
//   pipeline and queue fill, then input ready drops.
//   Reset (synchronous, active low) clears the control points to zero and
//   empties the queue, pipeline and output.
module cubic_bezier_eval_subdivide_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  cbez_pkg::t_in_item                    i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output cbez_pkg::t_out_item                   o_out_data,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [cbez_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [cbez_pkg::COORD_BITS-1:0]       i_cfg_data
);

    cbez_pkg::t_cfg_regs r_cfg;
    logic                push_valid;
    logic                push_ready;
    cbez_pkg::t_job      push_data;
    logic                pop_valid;
    logic                pop_ready;
    cbez_pkg::t_job      pop_data;

    // Control point registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid &&
                     (i_cfg_index < cbez_pkg::CFG_IDX_BITS'(cbez_pkg::NUM_REGS))) begin
            r_cfg[i_cfg_index[cbez_pkg::REG_SEL_BITS-1:0]] <= i_cfg_data;
        end
    end

    cbez_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    cbez_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    cbez_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (pop_valid),
        .o_job_ready (pop_ready),
        .i_job       (pop_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- hdl/cbez_checker.sv -----
// Port-level checks on the result channel of the Bezier unit, bound to the
// top level. Depends on cbez_pkg.
module cbez_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input cbez_pkg::t_out_item o_out_data
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // The last flag only appears at index 0 (evaluate) or index 7 (subdivide)
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.last_point |->
            (o_out_data.point_index == '0) ||
            (o_out_data.point_index == cbez_pkg::LAST_IDX))
        else $error("last flag on a middle point");

    // Index 7 always closes the run
    a_idx_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last_point |->
            (o_out_data.point_index != cbez_pkg::LAST_IDX))
        else $error("index 7 without last flag");

    // First cycle out of reset shows an empty output
    a_rst_clear: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind cubic_bezier_eval_subdivide_top cbez_checker u_cbez_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
